FILE: src/matrix_vector_multiply_core_defines.svh
// assertion macros shared by the matrix-vector multiply rtl
// needs a clock named clk and an active-low reset named arst_n in the using scope
`ifndef MATRIX_VECTOR_MULTIPLY_CORE_DEFINES_SVH
`define MATRIX_VECTOR_MULTIPLY_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// general property, checked outside reset
`define MVM_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("mvm check failed");

// same-cycle implication, checked outside reset
`define MVM_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mvm implication failed");

`else

`define MVM_ASSERT(label, prop)
`define MVM_ASSERT_IMP(label, ante, cons)

`endif

`endif

FILE: src/mvm_pkg.sv
// shared constants, types and state codes of the matrix-vector multiply core
// no dependencies
`default_nettype none

package mvm_pkg;

	// store geometry
	localparam int ROWS_MAX = 64;
	localparam int COLS_MAX = 256;
	localparam int ROW_W    = $clog2(ROWS_MAX);
	localparam int COL_W    = $clog2(COLS_MAX);
	localparam int WADDR_W  = ROW_W + COL_W;
	localparam int WDEPTH   = ROWS_MAX * COLS_MAX;

	// datapath widths
	localparam int VAL_W  = 16;
	localparam int PROD_W = 2 * VAL_W;
	localparam int ACC_W  = 40;
	localparam int SUM_W  = 32;

	// configuration registers
	localparam int OUT_COUNT_W = 7;
	localparam int IN_COUNT_W  = 9;
	localparam int CFG_DATA_W  = 9;
	localparam int CFG_IDX_W   = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_OUT_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_IN_COUNT  = 1'b1;

	localparam logic [OUT_COUNT_W-1:0] OUT_COUNT_RST = OUT_COUNT_W'(64);
	localparam logic [IN_COUNT_W-1:0]  IN_COUNT_RST  = IN_COUNT_W'(256);

	// item opcodes
	localparam logic OP_WEIGHT = 1'b0;
	localparam logic OP_VECTOR = 1'b1;

	// saturation limits of the result
	localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN
	} mvm_state_t;

	// one multiply-accumulate beat from the sequencer
	typedef struct packed {
		logic valid;
		logic first;
		logic final_col;
	} mvm_beat_t;

	// tag of the row being summed
	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic             last_row;
	} mvm_tag_t;

endpackage

`default_nettype wire

FILE: src/mvm_store.sv
// weight and vector memories: one write port fed by input beats,
// one registered read port driven by the sequencer; uses mvm_pkg
`default_nettype none

module mvm_store import mvm_pkg::*; (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic             wr_op,
	input  wire logic [ROW_W-1:0] wr_row,
	input  wire logic [COL_W-1:0] wr_col,
	input  wire logic [VAL_W-1:0] wr_value,
	input  wire logic             rd_en,
	input  wire logic [ROW_W-1:0] rd_row,
	input  wire logic [COL_W-1:0] rd_col,
	output logic      [VAL_W-1:0] w_data,
	output logic      [VAL_W-1:0] x_data
);

	logic [VAL_W-1:0] weight_mem [WDEPTH];
	logic [VAL_W-1:0] vector_mem [COLS_MAX];

	// weight memory, row-major addressing
	always_ff @(posedge clk) begin
		if (wr_en && wr_op == OP_WEIGHT) begin
			weight_mem[{wr_row, wr_col}] <= wr_value;
		end
		if (rd_en) begin
			w_data <= weight_mem[{rd_row, rd_col}];
		end
	end

	// vector memory
	always_ff @(posedge clk) begin
		if (wr_en && wr_op == OP_VECTOR) begin
			vector_mem[wr_col] <= wr_value;
		end
		if (rd_en) begin
			x_data <= vector_mem[rd_col];
		end
	end

endmodule

`default_nettype wire

FILE: src/mvm_mac.sv
// shared multiply-accumulate unit with saturation and the result register
// uses mvm_pkg and the assertion macros
`default_nettype none
`include "matrix_vector_multiply_core_defines.svh"

module mvm_mac import mvm_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire mvm_beat_t        beat,
	input  wire mvm_tag_t         tag,
	input  wire logic [VAL_W-1:0] w_data,
	input  wire logic [VAL_W-1:0] x_data,
	output logic                  xfer,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic      [ROW_W-1:0] out_row,
	output logic      [SUM_W-1:0] sum,
	output logic                  end_of_vector
);

	logic                    valid_s1, first_s1, final_s1;
	logic                    valid_s2, first_s2, final_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic        [ACC_W-1:0]  acc_q;
	logic                    done_q;
	logic        [SUM_W-1:0]  sat_sum;
	logic        [ACC_W-1:0]  prod_ext;

	// beat flags follow the memory read latency
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= beat.valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= beat.first;
		final_s1 <= beat.final_col;
		first_s2 <= first_s1;
		final_s2 <= final_s1;
	end

	// single 16x16 signed multiplier
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			prod_s2 <= $signed(w_data) * $signed(x_data);
		end
	end

	assign prod_ext = {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};

	// 40-bit wrapping accumulator, restarted on the first column
	always_ff @(posedge clk) begin
		if (valid_s2) begin
			acc_q <= first_s2 ? prod_ext : acc_q + prod_ext;
		end
	end

	// row complete flag, cleared when the sum moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else if (valid_s2 && final_s2) begin
			done_q <= 1'b1;
		end else if (xfer) begin
			done_q <= 1'b0;
		end
	end

	// saturate to the signed 32-bit range
	always_comb begin
		if (&acc_q[ACC_W-1:SUM_W-1] || ~|acc_q[ACC_W-1:SUM_W-1]) begin
			sat_sum = acc_q[SUM_W-1:0];
		end else if (acc_q[ACC_W-1]) begin
			sat_sum = SUM_MIN;
		end else begin
			sat_sum = SUM_MAX;
		end
	end

	assign xfer = done_q && (!out_valid || !out_stall);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (xfer) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			sum           <= sat_sum;
			out_row       <= tag.row;
			end_of_vector <= tag.last_row;
		end
	end

	// no beat may reach the accumulator while a finished row waits
	`MVM_ASSERT_IMP(a_no_beat_on_done, valid_s2, !done_q)
	// the final column always leaves a finished row behind
	`MVM_ASSERT(a_final_sets_done, (valid_s2 && final_s2) |=> done_q)
	// a result appears only from a finished row
	`MVM_ASSERT(a_out_from_done, $rose(out_valid) |-> $past(done_q))

endmodule

`default_nettype wire

FILE: src/mvm_ctrl.sv
// sequencer: walks rows and columns through the shared multiply-accumulate unit
// uses mvm_pkg and the assertion macros
`default_nettype none
`include "matrix_vector_multiply_core_defines.svh"

module mvm_ctrl import mvm_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [OUT_COUNT_W-1:0] out_count,
	input  wire logic [IN_COUNT_W-1:0]  in_count,
	input  wire logic                   xfer,
	output logic                        busy,
	output mvm_beat_t                   beat,
	output mvm_tag_t                    tag,
	output logic      [ROW_W-1:0]       rd_row,
	output logic      [COL_W-1:0]       rd_col
);

	localparam logic [OUT_COUNT_W-1:0] ROWS_LIM = OUT_COUNT_W'(ROWS_MAX);
	localparam logic [IN_COUNT_W-1:0]  COLS_LIM = IN_COUNT_W'(COLS_MAX);

	mvm_state_t       state_q, state_d;
	logic [ROW_W-1:0] row_q, rows_last_q, rows_last_d;
	logic [COL_W-1:0] col_q, cols_last_q, cols_last_d;
	logic [OUT_COUNT_W-1:0] rows_m1;
	logic [IN_COUNT_W-1:0]  cols_m1;

	// clamp the counts: zero acts as one, large values stop at the store size
	always_comb begin
		rows_m1 = out_count - OUT_COUNT_W'(1);
		cols_m1 = in_count - IN_COUNT_W'(1);
		if (out_count == '0) begin
			rows_last_d = '0;
		end else if (out_count > ROWS_LIM) begin
			rows_last_d = ROW_W'(ROWS_MAX - 1);
		end else begin
			rows_last_d = rows_m1[ROW_W-1:0];
		end
		if (in_count == '0) begin
			cols_last_d = '0;
		end else if (in_count > COLS_LIM) begin
			cols_last_d = COL_W'(COLS_MAX - 1);
		end else begin
			cols_last_d = cols_m1[COL_W-1:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_ISSUE;
			end
			ST_ISSUE: begin
				if (col_q == cols_last_q) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (xfer) state_d = (row_q == rows_last_q) ? ST_IDLE : ST_ISSUE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy           = (state_q != ST_IDLE);
		beat.valid     = (state_q == ST_ISSUE);
		beat.first     = (col_q == '0);
		beat.final_col = (col_q == cols_last_q);
		tag.row        = row_q;
		tag.last_row   = (row_q == rows_last_q);
		rd_row         = row_q;
		rd_col         = col_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// row and column counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			col_q       <= '0;
			rows_last_q <= '0;
			cols_last_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						row_q       <= '0;
						col_q       <= '0;
						rows_last_q <= rows_last_d;
						cols_last_q <= cols_last_d;
					end
				end
				ST_ISSUE: begin
					col_q <= (col_q == cols_last_q) ? '0 : col_q + COL_W'(1);
				end
				ST_DRAIN: begin
					if (xfer && row_q != rows_last_q) row_q <= row_q + ROW_W'(1);
				end
				default: ;
			endcase
		end
	end

	// column counter never runs past the row length
	`MVM_ASSERT_IMP(a_col_range, state_q == ST_ISSUE, col_q <= cols_last_q)
	// draining waits for the finished row to move out
	`MVM_ASSERT(a_drain_hold, (state_q == ST_DRAIN && !xfer) |=> state_q == ST_DRAIN)

endmodule

`default_nettype wire

FILE: src/matrix_vector_multiply_core.sv
// top level of the matrix-vector multiply core: configuration registers,
// input handshake and wiring; uses mvm_pkg, mvm_store, mvm_ctrl, mvm_mac
`default_nettype none

// Dense matrix-vector product for a fully connected layer. Opcode-0 beats write
// one Q8.8 weight at (row_index, column_index); opcode-1 beats write one vector
// element at column_index. A beat with last set starts the product after its
// own write, and the core returns out_count sums (clamped to 1..64; Q16.16,
// saturated to 32 bits) in row order, the final one flagged end_of_vector.
// Weights persist between vectors. After a last beat the core stalls its input
// until every row is done, longer if the result side stalls: a single
// multiply-accumulate unit takes one product per cycle from the weight memory's
// read port, and each row drains through the read, product and accumulator
// registers before the next starts. Results may still wait at the output while
// new beats are taken. Entries never written read as whatever the memories hold.

module matrix_vector_multiply_core import mvm_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	// input beats
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  opcode,
	input  wire logic [ROW_W-1:0]      row_index,
	input  wire logic [COL_W-1:0]      column_index,
	input  wire logic [VAL_W-1:0]      value,
	input  wire logic                  last,
	// result beats
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic      [ROW_W-1:0]      out_row,
	output logic      [SUM_W-1:0]      sum,
	output logic                       end_of_vector
);

	logic [OUT_COUNT_W-1:0] out_count_q;
	logic [IN_COUNT_W-1:0]  in_count_q;
	logic                   in_accept;
	logic                   busy;
	logic                   xfer;
	mvm_beat_t              beat;
	mvm_tag_t               tag;
	logic [ROW_W-1:0]       rd_row;
	logic [COL_W-1:0]       rd_col;
	logic [VAL_W-1:0]       w_data;
	logic [VAL_W-1:0]       x_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_count_q <= OUT_COUNT_RST;
			in_count_q  <= IN_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_OUT_COUNT: out_count_q <= cfg_data[OUT_COUNT_W-1:0];
				CFG_IN_COUNT:  in_count_q  <= cfg_data[IN_COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// input handshake: held off while a product runs
	assign in_stall  = busy;
	assign in_accept = in_valid && !busy;

	mvm_store u_store (
		.clk      (clk),
		.wr_en    (in_accept),
		.wr_op    (opcode),
		.wr_row   (row_index),
		.wr_col   (column_index),
		.wr_value (value),
		.rd_en    (beat.valid),
		.rd_row   (rd_row),
		.rd_col   (rd_col),
		.w_data   (w_data),
		.x_data   (x_data)
	);

	mvm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_accept && last),
		.out_count (out_count_q),
		.in_count  (in_count_q),
		.xfer      (xfer),
		.busy      (busy),
		.beat      (beat),
		.tag       (tag),
		.rd_row    (rd_row),
		.rd_col    (rd_col)
	);

	mvm_mac u_mac (
		.clk           (clk),
		.arst_n        (arst_n),
		.beat          (beat),
		.tag           (tag),
		.w_data        (w_data),
		.x_data        (x_data),
		.xfer          (xfer),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_row       (out_row),
		.sum           (sum),
		.end_of_vector (end_of_vector)
	);

endmodule

`default_nettype wire
